/* hdl/lrlc_pkg.sv */
package lrlc_pkg;

  localparam int unsigned MAX_CLUSTERS = 64;
  localparam int unsigned IDX_W        = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CNT_W        = $clog2(MAX_CLUSTERS + 1);

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned NUM_W  = 2 * VAL_W + 1;
  localparam int unsigned DEN_W  = VAL_W + 1;
  localparam int unsigned STEP_W = $clog2(VAL_W + 1);

  localparam logic [VAL_W-1:0] DELTA_RESET = 16'd160;
  localparam logic [VAL_W-1:0] CNT_MAX     = '1;

  typedef struct packed {
    logic [VAL_W-1:0] line_rho;
    logic [VAL_W-1:0] line_theta;
    logic             frame_end;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] mean_rho;
    logic [VAL_W-1:0] mean_theta;
    logic             last_cluster;
    logic             overflowed;
  } out_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] rho;
    logic [VAL_W-1:0] theta;
    logic [VAL_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic             ld_item;
    logic             cap_entry;
    logic             mul_theta;
    logic             mul_go;
    logic             div_start;
    logic             cap_rho;
    logic             cap_theta;
    logic             ram_we;
    logic             wr_new;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic             out_load;
    logic             out_last;
    logic             out_ovf;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic div_busy;
    logic out_free;
    logic frame_end;
  } status_t;

endpackage

/* hdl/lrlc_ram.sv */
module lrlc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/lrlc_div.sv */
module lrlc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lrlc_pkg::NUM_W-1:0]  num_i,
  input  logic [lrlc_pkg::DEN_W-1:0]  den_i,
  output logic                        busy_o,
  output logic [lrlc_pkg::VAL_W-1:0]  quot_o
);

  logic                        busy_q, busy_d;
  logic [lrlc_pkg::STEP_W-1:0] step_q, step_d;
  logic [lrlc_pkg::DEN_W-1:0]  rem_q, rem_d;
  logic [lrlc_pkg::VAL_W-1:0]  lo_q, lo_d;
  logic [lrlc_pkg::DEN_W-1:0]  den_q, den_d;
  logic [lrlc_pkg::DEN_W:0]    trial;
  logic                        qbit;

  // quotient is known to fit VAL_W bits, so the top half starts below den
  always_comb begin
    trial  = {rem_q, lo_q[lrlc_pkg::VAL_W-1]};
    qbit   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = lrlc_pkg::STEP_W'(lrlc_pkg::VAL_W);
      rem_d  = num_i[lrlc_pkg::NUM_W-1:lrlc_pkg::VAL_W];
      lo_d   = num_i[lrlc_pkg::VAL_W-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = qbit ? lrlc_pkg::DEN_W'(trial - {1'b0, den_q})
                    : trial[lrlc_pkg::DEN_W-1:0];
      lo_d   = {lo_q[lrlc_pkg::VAL_W-2:0], qbit};
      step_d = step_q - 1'b1;
      if (step_q == lrlc_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = lo_q;

endmodule

/* hdl/lrlc_dp.sv */
module lrlc_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lrlc_pkg::in_word_t         in_data_i,
  input  logic                       cfg_valid_i,
  input  logic [lrlc_pkg::VAL_W-1:0] cfg_data_i,
  input  lrlc_pkg::cmd_t             cmd_i,
  output lrlc_pkg::status_t          status_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lrlc_pkg::out_word_t        out_data_o
);

  lrlc_pkg::in_word_t         item_q;
  lrlc_pkg::entry_t           ent_q;
  lrlc_pkg::entry_t           rdata;
  lrlc_pkg::entry_t           wdata;
  lrlc_pkg::out_word_t        out_q, out_d;
  logic [lrlc_pkg::VAL_W-1:0] delta_q;
  logic [lrlc_pkg::NUM_W-1:0] num_q, num_d;
  logic [lrlc_pkg::DEN_W-1:0] den_q;
  logic [lrlc_pkg::VAL_W-1:0] new_rho_q, new_theta_q;
  logic [lrlc_pkg::VAL_W-1:0] mul_mean, mul_x, diff, cnt_inc, quot;
  logic                       out_valid_q, out_valid_d;
  logic                       div_busy;

  lrlc_ram #(
    .WIDTH($bits(lrlc_pkg::entry_t)),
    .DEPTH(lrlc_pkg::MAX_CLUSTERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(cmd_i.ram_waddr),
    .wdata_i(wdata),
    .raddr_i(cmd_i.ram_raddr),
    .rdata_o(rdata)
  );

  lrlc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  always_comb begin
    diff     = (item_q.line_rho >= rdata.rho) ? item_q.line_rho - rdata.rho
                                              : rdata.rho - item_q.line_rho;
    mul_mean = cmd_i.mul_theta ? ent_q.theta : ent_q.rho;
    mul_x    = cmd_i.mul_theta ? item_q.line_theta : item_q.line_rho;
    num_d    = lrlc_pkg::NUM_W'(mul_mean) * lrlc_pkg::NUM_W'(ent_q.cnt)
             + lrlc_pkg::NUM_W'(mul_x);
    cnt_inc  = (ent_q.cnt == lrlc_pkg::CNT_MAX) ? ent_q.cnt : ent_q.cnt + 1'b1;
    if (cmd_i.wr_new) begin
      wdata = '{rho: item_q.line_rho, theta: item_q.line_theta,
                cnt: lrlc_pkg::VAL_W'(1)};
    end else begin
      wdata = '{rho: new_rho_q, theta: new_theta_q, cnt: cnt_inc};
    end
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_d = '{mean_rho: rdata.rho, mean_theta: rdata.theta,
                last_cluster: cmd_i.out_last, overflowed: cmd_i.out_ovf};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      delta_q     <= lrlc_pkg::DELTA_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        delta_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.ld_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.cap_entry) begin
      ent_q <= rdata;
    end
    if (cmd_i.mul_go) begin
      num_q <= num_d;
      den_q <= {1'b0, ent_q.cnt} + 1'b1;
    end
    if (cmd_i.cap_rho) begin
      new_rho_q <= quot;
    end
    if (cmd_i.cap_theta) begin
      new_theta_q <= quot;
    end
  end

  assign status_o = '{match: (diff < delta_q), div_busy: div_busy,
                      out_free: (!out_valid_q || out_ready_i),
                      frame_end: item_q.frame_end};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/lrlc_ctrl.sv */
module lrlc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrlc_pkg::status_t status_i,
  output lrlc_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_MULR = 4'd3;
  localparam logic [3:0] S_DSR  = 4'd4;
  localparam logic [3:0] S_DWR  = 4'd5;
  localparam logic [3:0] S_MULT = 4'd6;
  localparam logic [3:0] S_DST  = 4'd7;
  localparam logic [3:0] S_DWT  = 4'd8;
  localparam logic [3:0] S_UPD  = 4'd9;
  localparam logic [3:0] S_NEW  = 4'd10;
  localparam logic [3:0] S_ERD  = 4'd11;
  localparam logic [3:0] S_ELD  = 4'd12;

  logic [3:0]                 state_q, state_d;
  logic [lrlc_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [lrlc_pkg::CNT_W-1:0] n_q, n_d;
  logic                       drop_q, drop_d;
  logic [lrlc_pkg::CNT_W-1:0] idx_nxt;

  always_comb begin
    idx_nxt    = idx_q + 1'b1;
    state_d    = state_q;
    idx_d      = idx_q;
    n_d        = n_q;
    drop_d     = drop_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.ram_raddr = idx_q[lrlc_pkg::IDX_W-1:0];
    cmd_o.ram_waddr = idx_q[lrlc_pkg::IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          idx_d   = '0;
          state_d = (n_q == '0) ? S_NEW : S_SRD;
        end
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        // next entry is fetched while this one is compared
        cmd_o.ram_raddr = idx_nxt[lrlc_pkg::IDX_W-1:0];
        if (status_i.match) begin
          cmd_o.cap_entry = 1'b1;
          state_d = S_MULR;
        end else if (idx_nxt == n_q) begin
          state_d = S_NEW;
        end else begin
          idx_d = idx_nxt;
        end
      end
      S_MULR: begin
        cmd_o.mul_go = 1'b1;
        state_d = S_DSR;
      end
      S_DSR: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWR;
      end
      S_DWR: begin
        if (!status_i.div_busy) begin
          cmd_o.cap_rho = 1'b1;
          state_d = S_MULT;
        end
      end
      S_MULT: begin
        cmd_o.mul_theta = 1'b1;
        cmd_o.mul_go    = 1'b1;
        state_d = S_DST;
      end
      S_DST: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWT;
      end
      S_DWT: begin
        if (!status_i.div_busy) begin
          cmd_o.cap_theta = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.ram_we = 1'b1;
        idx_d   = '0;
        state_d = status_i.frame_end ? S_ERD : S_IDLE;
      end
      S_NEW: begin
        cmd_o.ram_waddr = n_q[lrlc_pkg::IDX_W-1:0];
        if (n_q < lrlc_pkg::CNT_W'(lrlc_pkg::MAX_CLUSTERS)) begin
          cmd_o.ram_we = 1'b1;
          cmd_o.wr_new = 1'b1;
          n_d = n_q + 1'b1;
        end else begin
          drop_d = 1'b1;
        end
        idx_d   = '0;
        state_d = status_i.frame_end ? S_ERD : S_IDLE;
      end
      S_ERD: begin
        state_d = S_ELD;
      end
      S_ELD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (idx_nxt == n_q);
          cmd_o.out_ovf  = drop_q;
          if (idx_nxt == n_q) begin
            n_d     = '0;
            drop_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_nxt;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      drop_q  <= drop_d;
    end
  end

  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= lrlc_pkg::CNT_W'(lrlc_pkg::MAX_CLUSTERS))
    else $error("cluster count beyond table depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("output register overwritten");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> (n_q == '0 && !drop_q))
    else $error("table not cleared after frame");

  a_quot_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cap_rho || cmd_o.cap_theta) |-> !status_i.div_busy)
    else $error("quotient taken while divider busy");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (idx_q < n_q))
    else $error("emit index outside table");

endmodule

/* hdl/line_rho_leader_clustering_unit.sv */
// Leader clustering of (rho, theta) lines: a line joins the first cluster, in creation
// order, whose mean rho lies strictly within delta_rho, updating the running means;
// otherwise it opens a cluster, or is dropped with the overflow flag set when all
// MAX_CLUSTERS are used. The frame_end word drains every cluster in order, then clears.
// One word at a time: the time a line takes is set by the one-per-cycle table read over
// the clusters that it scans and, for a line that joins a cluster, by the 16-step shared
// divider run twice; a frame end reads and emits each cluster in turn, waiting on any
// output stall. Input is taken while the last result still waits in the output
// register.
module line_rho_leader_clustering_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lrlc_pkg::in_word_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lrlc_pkg::out_word_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lrlc_pkg::VAL_W-1:0] cfg_data_i
);

  lrlc_pkg::cmd_t    cmd;
  lrlc_pkg::status_t status;

  lrlc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lrlc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  assign cfg_ready_o = 1'b1;

endmodule
